// ===== src/nls_pkg.sv =====
// Shared types and constants for the numeric literal scanner.
// Used by nls_core and numeric_literal_scanner; no dependencies.
package nls_pkg;

  // Literal kinds reported with each result
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_INT   = 3'd0;
  localparam kind_t KIND_UINT  = 3'd1;
  localparam kind_t KIND_REAL  = 3'd2;
  localparam kind_t KIND_LREAL = 3'd3;
  localparam kind_t KIND_BAD   = 3'd4;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [4:0] FRAC_MAX   = 5'd19;
  localparam logic [1:0] COUNT_MAX  = 2'd3;

  // One finished literal, as handed from the core to the result register
  typedef struct packed {
    logic        valid;
    logic [63:0] int_value;
    logic [63:0] frac_value;
    logic [4:0]  frac_digits;
    kind_t       lit_kind;
    logic        ends_before;
  } result_t;

endpackage

// ===== src/nls_core.sv =====
// Literal scanning state and next-state logic for one source byte per step.
// Depends on nls_pkg for kinds, constants and the result struct.
module nls_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        ch,
  input  logic              eot,
  output nls_pkg::result_t  res
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ZERO   = 3'd1,
    PH_OCT    = 3'd2,
    PH_HEX    = 3'd3,
    PH_DEC    = 3'd4,
    PH_SUFFIX = 3'd5,
    PH_FRAC   = 3'd6
  } phase_t;

  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_LA  = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF  = 8'h66;  // 'f'
  localparam logic [7:0] CH_LL  = 8'h6c;  // 'l'
  localparam logic [7:0] CH_LU  = 8'h75;  // 'u'
  localparam logic [7:0] CH_LX  = 8'h78;  // 'x'
  localparam logic [7:0] CH_CASE = 8'h20;
  localparam logic [7:0] CH_NINE = 8'h39;

  phase_t      phase_r, phase_nxt;
  logic [63:0] accum_r, accum_nxt;
  logic [1:0]  ucnt_r, ucnt_nxt;
  logic [1:0]  lcnt_r, lcnt_nxt;
  logic [63:0] frac_r, frac_nxt;
  logic [4:0]  fcnt_r, fcnt_nxt;

  logic        dig;
  logic [3:0]  d;
  logic [7:0]  lc;
  logic        is_u, is_l, is_ul, is_hex_letter;
  logic [3:0]  hex_val;
  logic [63:0] acc_x8, acc_x10, acc_x16, acc_hexl, frac_x10;
  logic        emit_c, ends_c, start_c;
  nls_pkg::kind_t kind_c, pend_kind;

  // Classify the byte
  always_comb begin
    lc            = ch | CH_CASE;
    dig           = (ch >= nls_pkg::ASCII_ZERO) && (ch <= CH_NINE);
    d             = dig ? 4'(ch - nls_pkg::ASCII_ZERO) : 4'd0;
    is_u          = (lc == CH_LU);
    is_l          = (lc == CH_LL);
    is_ul         = is_u || is_l;
    is_hex_letter = (lc >= CH_LA) && (lc <= CH_LF);
    hex_val       = 4'(lc - CH_LA + 8'd10);
  end

  // Constant multiply-adds as shifts and adds
  always_comb begin
    acc_x8   = {accum_r[60:0], 3'b000} + {60'd0, d};
    acc_x16  = {accum_r[59:0], 4'b0000} + {60'd0, d};
    acc_hexl = {accum_r[59:0], 4'b0000} + {60'd0, hex_val};
    acc_x10  = {accum_r[60:0], 3'b000} + {accum_r[62:0], 1'b0} + {60'd0, d};
    frac_x10 = {frac_r[60:0], 3'b000} + {frac_r[62:0], 1'b0} + {60'd0, d};
  end

  // Kind of the literal in progress when something ends it
  always_comb begin
    pend_kind = nls_pkg::KIND_INT;
    if (phase_r == PH_FRAC) begin
      pend_kind = nls_pkg::KIND_REAL;
    end else if (phase_r == PH_SUFFIX) begin
      if (ucnt_r > 2'd1 || lcnt_r > 2'd2) begin
        pend_kind = nls_pkg::KIND_BAD;
      end else if (ucnt_r != 2'd0) begin
        pend_kind = nls_pkg::KIND_UINT;
      end
    end
  end

  // Next state and result for one byte
  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    ucnt_nxt  = ucnt_r;
    lcnt_nxt  = lcnt_r;
    frac_nxt  = frac_r;
    fcnt_nxt  = fcnt_r;
    emit_c    = 1'b0;
    ends_c    = 1'b0;
    start_c   = 1'b0;
    kind_c    = nls_pkg::KIND_INT;

    if (step) begin
      if (eot) begin
        // Flush whatever is pending; nothing to re-lex
        if (phase_r != PH_IDLE && phase_r != phase_t'(3'd7)) begin
          emit_c = 1'b1;
          kind_c = pend_kind;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end else begin
        unique case (phase_r)
          PH_ZERO: begin
            if (lc == CH_LX) begin
              phase_nxt = PH_HEX;
            end else if (ch == CH_DOT) begin
              phase_nxt = PH_FRAC;
            end else if (dig && !d[3]) begin
              phase_nxt = PH_OCT;
              accum_nxt = {60'd0, d};
            end else if (is_ul) begin
              phase_nxt = PH_SUFFIX;
            end else begin
              emit_c  = 1'b1;
              ends_c  = 1'b1;
              start_c = dig;
            end
          end
          PH_OCT: begin
            if (dig && !d[3]) begin
              accum_nxt = acc_x8;
            end else if (is_ul && accum_r == 64'd0) begin
              phase_nxt = PH_SUFFIX;
            end else begin
              emit_c  = 1'b1;
              ends_c  = 1'b1;
              start_c = dig;
            end
          end
          PH_HEX: begin
            if (dig) begin
              accum_nxt = acc_x16;
            end else if (is_hex_letter) begin
              accum_nxt = acc_hexl;
            end else begin
              emit_c = 1'b1;
              ends_c = 1'b1;
            end
          end
          PH_DEC: begin
            if (dig) begin
              accum_nxt = acc_x10;
            end else if (ch == CH_DOT) begin
              phase_nxt = PH_FRAC;
            end else if (is_ul) begin
              phase_nxt = PH_SUFFIX;
            end else begin
              emit_c = 1'b1;
              ends_c = 1'b1;
            end
          end
          PH_SUFFIX: begin
            if (!is_ul) begin
              emit_c  = 1'b1;
              ends_c  = 1'b1;
              kind_c  = pend_kind;
              start_c = dig;
            end
          end
          PH_FRAC: begin
            if (dig) begin
              frac_nxt = frac_x10;
              if (fcnt_r < nls_pkg::FRAC_MAX) fcnt_nxt = fcnt_r + 5'd1;
            end else if (is_l) begin
              emit_c = 1'b1;
              kind_c = nls_pkg::KIND_LREAL;
            end else if (lc == CH_LF) begin
              emit_c = 1'b1;
              kind_c = nls_pkg::KIND_REAL;
            end else begin
              emit_c = 1'b1;
              ends_c = 1'b1;
              kind_c = nls_pkg::KIND_REAL;
            end
          end
          default: begin
            // Idle, and the unused code treated as idle
            phase_nxt = PH_IDLE;
            start_c   = dig;
          end
        endcase

        // Count u/l suffix letters, saturating
        if (!emit_c && is_ul &&
            (phase_r == PH_SUFFIX || phase_nxt == PH_SUFFIX)) begin
          if (is_u) begin
            if (ucnt_r < nls_pkg::COUNT_MAX) ucnt_nxt = ucnt_r + 2'd1;
          end else begin
            if (lcnt_r < nls_pkg::COUNT_MAX) lcnt_nxt = lcnt_r + 2'd1;
          end
        end
      end

      // Drop the finished literal, then open a new one on a digit
      if (emit_c || start_c) begin
        phase_nxt = PH_IDLE;
        accum_nxt = 64'd0;
        ucnt_nxt  = 2'd0;
        lcnt_nxt  = 2'd0;
        frac_nxt  = 64'd0;
        fcnt_nxt  = 5'd0;
      end
      if (start_c) begin
        phase_nxt = (d == 4'd0) ? PH_ZERO : PH_DEC;
        accum_nxt = {60'd0, d};
      end
    end
  end

  // Shape the result from the state before this byte
  always_comb begin
    res.valid       = emit_c;
    res.int_value   = (kind_c == nls_pkg::KIND_UINT) ? {32'd0, accum_r[31:0]} : accum_r;
    res.frac_value  = (kind_c == nls_pkg::KIND_REAL || kind_c == nls_pkg::KIND_LREAL)
                      ? frac_r : 64'd0;
    res.frac_digits = (kind_c == nls_pkg::KIND_REAL || kind_c == nls_pkg::KIND_LREAL)
                      ? fcnt_r : 5'd0;
    res.lit_kind    = kind_c;
    res.ends_before = ends_c;
  end

  // Hold the literal in progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      accum_r <= 64'd0;
      ucnt_r  <= 2'd0;
      lcnt_r  <= 2'd0;
      frac_r  <= 64'd0;
      fcnt_r  <= 5'd0;
    end else begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      ucnt_r  <= ucnt_nxt;
      lcnt_r  <= lcnt_nxt;
      frac_r  <= frac_nxt;
      fcnt_r  <= fcnt_nxt;
    end
  end

endmodule

// ===== src/numeric_literal_scanner.sv =====
// Top level of the numeric literal scanner: stream ports, input and result registers.
// Depends on nls_pkg and nls_core.
//
// Scans C-style numeric literals (decimal, octal, hex, reals with a fraction)
// from a byte stream, one byte per transfer, and sends one result per finished
// literal. The block takes a byte every cycle while results are being taken;
// a byte that causes a result sits in the input register while the scanner
// core's combinational shift-and-add logic works out the result, which is
// then registered in the result register. Set in_tlast to mark end of text:
// it flushes the pending literal and in_tdata is ignored. ends_before in a
// result means the byte that ended the literal is not part of it and should
// be lexed again by the consumer.
module numeric_literal_scanner (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] ch
  input  logic         in_tlast,   // end_of_text
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // [63:0] int_value, [127:64] frac_value,
                                   // [132:128] frac_digits, [135:133] zero
  output logic [3:0]   out_tuser   // [2:0] lit_kind, [3] ends_before
);

  logic             in_valid_r;
  logic [7:0]       ch_r;
  logic             eot_r;
  logic             step;
  nls_pkg::result_t res;
  logic             out_valid_r;
  nls_pkg::result_t out_r;

  // Advance the held byte when the result register is free or draining
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  // Hold the accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      ch_r  <= in_tdata;
      eot_r <= in_tlast;
    end
  end

  nls_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ch    (ch_r),
    .eot   (eot_r),
    .res   (res)
  );

  // Hold the result until transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (step && res.valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_r.frac_digits, out_r.frac_value, out_r.int_value};
  assign out_tuser  = {out_r.ends_before, out_r.lit_kind};

endmodule
